// ===== hdl/tlbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbm_pkg: shared types and constants of the translation table unit
// Field layout of the stream words, action codes, table geometry and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlbm_pkg;

  // Table geometry.
  localparam int ENTRY_COUNT = 64;
  localparam int IDX_W       = $clog2(ENTRY_COUNT);
  localparam int STEP_W      = $clog2(ENTRY_COUNT + 1);

  // Field widths.
  localparam int ACT_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int PN_W     = 22;
  localparam int SIZE_W   = 2;
  localparam int PAGE_SH  = 10;
  localparam int BYTES_W  = 21;
  localparam int REGION_W = 27;

  // Input word layout, lowest bit first.
  localparam int IN_ADDR_LO  = 0;
  localparam int IN_IDX_LO   = IN_ADDR_LO + ADDR_W;
  localparam int IN_VPN_LO   = IN_IDX_LO + IDX_W;
  localparam int IN_PPN_LO   = IN_VPN_LO + PN_W;
  localparam int IN_SIZE_LO  = IN_PPN_LO + PN_W;
  localparam int IN_AV_BIT   = IN_SIZE_LO + SIZE_W;
  localparam int IN_DV_BIT   = IN_AV_BIT + 1;
  localparam int IN_USED_W   = IN_DV_BIT + 1;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output word layout, lowest bit first.
  localparam int OUT_HIT_BIT   = 0;
  localparam int OUT_PHYS_LO   = OUT_HIT_BIT + 1;
  localparam int OUT_BYTES_LO  = OUT_PHYS_LO + ADDR_W;
  localparam int OUT_REGION_LO = OUT_BYTES_LO + BYTES_W;
  localparam int OUT_USED_W    = OUT_REGION_LO + REGION_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  // Reset value of the walk start register and the packed page size shifts.
  localparam logic [ADDR_W-1:0] REGION_BASE_RESET = 32'h0810_0000;
  localparam logic [31:0]       SIZE_SHIFTS       = 32'h1410_0c0a;

  // Action codes carried on the input tuser.
  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE     = 2'd0,
    ACT_TRANSLATE = 2'd1,
    ACT_MEASURE   = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic write;
    logic compare;
    logic select;
    logic step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic steps_last;
    logic measure;
    logic out_free;
  } sts_t;

  // Page size in bytes for a size code.
  function automatic logic [BYTES_W-1:0] page_bytes(input logic [SIZE_W-1:0] code);
    logic [7:0] sh;
    sh = 8'((SIZE_SHIFTS >> {code, 3'b000}) & 32'h0000_00ff);
    return BYTES_W'(1) << sh[4:0];
  endfunction

endpackage

// ===== hdl/tlbm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbm_ctrl: sequencing controller of the translation table unit
// Accepts one transaction at a time and steps the datapath through
// write, compare, select and accumulate phases until the result is loaded.
// ----------------------------------------------------------------------------
module tlbm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tlbm_pkg::ACT_W-1:0]    s_action,
  output tlbm_pkg::cmd_t                cmd,
  input  tlbm_pkg::sts_t                sts
);
  import tlbm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WR   = 6'b000010,
    S_CMP  = 6'b000100,
    S_SEL  = 6'b001000,
    S_ACC  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (s_action)
            ACT_WRITE:     state_next = S_WR;
            ACT_TRANSLATE: state_next = S_CMP;
            ACT_MEASURE:   state_next = S_CMP;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_WR: begin
        cmd.write  = 1'b1;
        state_next = S_DONE;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = S_SEL;
      end
      S_SEL: begin
        cmd.select = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        // A measure walk goes on while pages keep hitting and the step limit is not reached.
        cmd.step = 1'b1;
        if (sts.measure && sts.hit && !sts.steps_last) begin
          state_next = S_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tlbm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbm_datapath: table storage, lookup and walk arithmetic
// Holds the valid bits and page numbers in flops for the parallel compare,
// the physical side in a small memory, and the output register.
// ----------------------------------------------------------------------------
module tlbm_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tlbm_pkg::ADDR_W-1:0]        cfg_wdata,
  input  logic [tlbm_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [tlbm_pkg::ACT_W-1:0]         s_tuser,
  input  tlbm_pkg::cmd_t                     cmd,
  output tlbm_pkg::sts_t                     sts,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tlbm_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import tlbm_pkg::*;

  localparam int ENT_W = PN_W + SIZE_W;

  // Configuration and latched transaction fields.
  logic [ADDR_W-1:0]   region_base;
  logic [ACT_W-1:0]    act_q;
  logic [IDX_W-1:0]    idx_q;
  logic [PN_W-1:0]     vpn_q;
  logic [PN_W-1:0]     ppn_q;
  logic [SIZE_W-1:0]   size_q;
  logic                valid_q;

  // Table storage.
  logic [ENTRY_COUNT-1:0] entry_valid;
  logic [PN_W-1:0]        entry_vpn [ENTRY_COUNT];
  logic [ENT_W-1:0]       mem [ENTRY_COUNT];

  // Lookup and walk state.
  logic [ADDR_W-1:0]      lookup_addr;
  logic [ENTRY_COUNT-1:0] match_comb;
  logic [ENTRY_COUNT-1:0] match_vec;
  logic [IDX_W-1:0]       hit_idx;
  logic                   hit_q;
  logic [ENT_W-1:0]       ram_q;
  logic [BYTES_W-1:0]     hit_bytes;
  logic [REGION_W-1:0]    total;
  logic [STEP_W-1:0]      steps;

  // Result.
  logic [OUT_DATA_W-1:0]  result;
  logic                   out_valid;
  logic [OUT_DATA_W-1:0]  out_data;

  // Walk start register.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= REGION_BASE_RESET;
    end else if (cfg_we) begin
      region_base <= cfg_wdata;
    end
  end

  // Capture the accepted transaction and set up the first lookup address.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= s_tuser;
      idx_q   <= s_tdata[IN_IDX_LO +: IDX_W];
      vpn_q   <= s_tdata[IN_VPN_LO +: PN_W];
      ppn_q   <= s_tdata[IN_PPN_LO +: PN_W];
      size_q  <= s_tdata[IN_SIZE_LO +: SIZE_W];
      valid_q <= s_tdata[IN_AV_BIT] & s_tdata[IN_DV_BIT];
    end
  end

  // Valid bits clear at reset; an entry counts only with both valids set.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.write) begin
      entry_valid[idx_q] <= valid_q;
    end
  end

  // Virtual page numbers, each compared in place.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      entry_vpn[idx_q] <= vpn_q;
    end
  end

  // Physical page number and size code memory, read at the winning index.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[idx_q] <= {size_q, ppn_q};
    end
    if (cmd.select) begin
      ram_q <= mem[hit_idx];
    end
  end

  // Parallel compare of the lookup address against every entry.
  always_comb begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      match_comb[i] = entry_valid[i] && ({entry_vpn[i], PAGE_SH'(0)} == lookup_addr);
    end
  end

  // Lowest matching index wins.
  always_comb begin
    hit_idx = '0;
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit_bytes = hit_q ? page_bytes(ram_q[PN_W +: SIZE_W]) : '0;

  // Match vector, hit flag and walk accumulation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lookup_addr <= (s_tuser == ACT_MEASURE) ? region_base : s_tdata[IN_ADDR_LO +: ADDR_W];
      total       <= '0;
      steps       <= '0;
    end else if (cmd.step && (act_q == ACT_MEASURE) && hit_q) begin
      lookup_addr <= lookup_addr + ADDR_W'(hit_bytes);
      total       <= total + REGION_W'(hit_bytes);
      steps       <= steps + STEP_W'(1);
    end
    if (cmd.compare) begin
      match_vec <= match_comb;
    end
    if (cmd.select) begin
      hit_q <= |match_vec;
    end
  end

  // Result word. The walk total stays below 2^27 since at most
  // ENTRY_COUNT pages of at most 1 MB are summed.
  always_comb begin
    result = '0;
    case (act_q)
      ACT_TRANSLATE: begin
        result[OUT_HIT_BIT]              = hit_q;
        result[OUT_PHYS_LO +: ADDR_W]    = hit_q ? {ram_q[PN_W-1:0], PAGE_SH'(0)} : '1;
        result[OUT_BYTES_LO +: BYTES_W]  = hit_bytes;
      end
      ACT_MEASURE: begin
        result[OUT_REGION_LO +: REGION_W] = total;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Status to the controller.
  assign sts.hit        = hit_q;
  assign sts.steps_last = (steps == STEP_W'(ENTRY_COUNT - 1));
  assign sts.measure    = (act_q == ACT_MEASURE);
  assign sts.out_free   = !out_valid || m_tready;

endmodule

// ===== hdl/tlb_translate_and_region_measure_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_translate_and_region_measure_unit: 64-entry translation table
// Writes table entries, translates page addresses and measures the run of
// contiguous mapped pages that starts at a configurable base address.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries the action code on s_tuser and the address and
//   entry fields on s_tdata. Every input transaction yields exactly one
//   output transaction on m_tdata. cfg_we/cfg_wdata load the walk start
//   address; write it only while the unit is idle.
// Sequencing:
//   One transaction is in work at a time. A write passes the states S_WR
//   and S_DONE, a translate S_CMP, S_SEL, S_ACC and S_DONE. A measure runs
//   one lookup per pass through S_CMP, S_SEL and S_ACC (compare, memory
//   read at the winning index, add) and ends on a miss or when all 64 steps
//   hit. Each lookup goes through the shared compare array and the table
//   memory in turn.
// Reset:
//   rst clears every valid bit of the table and restores the walk start
//   address to 0x0810_0000; no clearing pass is needed.
// Stalls:
//   A result waits in the output register while m_tready is low; the unit
//   takes the next transaction meanwhile and holds its result until the
//   register is free.
// ----------------------------------------------------------------------------
module tlb_translate_and_region_measure_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tlbm_pkg::ADDR_W-1:0]         cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // page_addr, entry_index, entry_vpn, entry_ppn, entry_size_code,
  // entry_addr_valid, entry_data_valid, zero fill
  input  logic [tlbm_pkg::IN_DATA_W-1:0]      s_tdata,
  // action
  input  logic [tlbm_pkg::ACT_W-1:0]          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // hit, phys_addr, page_bytes, region_bytes, zero fill
  output logic [tlbm_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import tlbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_action (s_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  tlbm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // One transaction at a time: the unit is busy right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a transaction is in work");

  // A hit always reports exactly one page size.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[OUT_HIT_BIT]) |-> $onehot(m_tdata[OUT_BYTES_LO +: BYTES_W]))
    else $error("hit without a single page size");

  // Measured regions are whole 1 KB pages.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_REGION_LO +: PAGE_SH] == '0))
    else $error("region total not page aligned");

endmodule
